### hw/rtl/spjq_pkg.sv
// Package for the sorted priority job queue.
// Shared types, field widths and codes; no dependencies.
`default_nettype none

package spjq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned ID_W   = 16;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;

    // action codes (carried on tuser)
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // what one cell shows its neighbors
    typedef struct packed {
        logic              valid;
        logic              gt;     // holds a job ranked after the incoming one
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_cell_state;

    // command broadcast to every cell
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### hw/rtl/spjq_cell.sv
// One slot of the sorted queue: holds a job and shifts with its neighbors.
// Depends on spjq_pkg.
`default_nettype none

module spjq_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire spjq_pkg::t_cell_ctrl  i_ctrl,
    input  wire spjq_pkg::t_cell_state i_left,
    input  wire spjq_pkg::t_cell_state i_right,
    output spjq_pkg::t_cell_state      o_state
);

    logic                        r_valid;
    logic [spjq_pkg::ID_W-1:0]   r_id;
    logic [spjq_pkg::PRIO_W-1:0] r_prio;
    logic                        n_valid;
    logic [spjq_pkg::ID_W-1:0]   n_id;
    logic [spjq_pkg::PRIO_W-1:0] n_prio;
    logic                        w_gt;

    assign w_gt = r_valid && (r_prio > i_ctrl.prio);

    assign o_state.valid = r_valid;
    assign o_state.gt    = w_gt;
    assign o_state.id    = r_id;
    assign o_state.prio  = r_prio;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_prio  = r_prio;
        if (i_ctrl.push) begin
            if (i_left.gt) begin
                // make room: take the left neighbor's job
                n_valid = 1'b1;
                n_id    = i_left.id;
                n_prio  = i_left.prio;
            end else if (i_left.valid && (!r_valid || w_gt)) begin
                // insertion point: first slot past all smaller-or-equal jobs
                n_valid = 1'b1;
                n_id    = i_ctrl.id;
                n_prio  = i_ctrl.prio;
            end
        end else if (i_ctrl.pop) begin
            n_valid = i_right.valid;
            n_id    = i_right.id;
            n_prio  = i_right.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_job_queue_core.sv
// Sorted priority job queue: top level with the cell chain and the result register.
// Depends on spjq_pkg and spjq_cell.
//
// A bounded priority queue built as a row of DEPTH cells kept in ascending priority
// order, head in cell 0. Each input word is a push (tuser 0) of a job id and priority or
// a pop (tuser 1) of the head; equal priorities leave in arrival order. Every input word
// gives one output word with status (done, full, empty), the removed job on a successful
// pop (zero otherwise) and the occupancy after the word. All cells compare against the
// incoming priority and shift or load in the same cycle, and the result is registered, so
// a new word is taken every cycle while the output is drained. No clearing pass is needed
// after reset.
`default_nettype none

module sorted_priority_job_queue_core #(
    parameter int unsigned DEPTH = spjq_pkg::DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // job_id[15:0], job_priority[23:16]
    input  wire logic [0:0]  s_axis_tuser,   // action[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // status[1:0], removed_id[17:2],
                                             // removed_priority[25:18], occupancy[30:26]
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    spjq_pkg::t_cell_ctrl  w_ctrl;
    spjq_pkg::t_cell_state w_cell [DEPTH];
    spjq_pkg::t_cell_state w_edge_left;
    spjq_pkg::t_cell_state w_edge_right;

    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_action;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic [CNT_W+4:0]              w_count_ext;

    logic                          r_m_valid;
    logic [spjq_pkg::STAT_W-1:0]   r_status;
    logic [spjq_pkg::ID_W-1:0]     r_rid;
    logic [spjq_pkg::PRIO_W-1:0]   r_rprio;
    logic [spjq_pkg::OCC_W-1:0]    r_occ;
    logic [spjq_pkg::STAT_W-1:0]   n_status;
    logic [spjq_pkg::ID_W-1:0]     n_rid;
    logic [spjq_pkg::PRIO_W-1:0]   n_rprio;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_action      = s_axis_tuser[0];
    assign w_full        = w_cell[DEPTH-1].valid;
    assign w_empty       = !w_cell[0].valid;

    assign w_ctrl.push = w_accept && (w_action == spjq_pkg::ACT_PUSH) && !w_full;
    assign w_ctrl.pop  = w_accept && (w_action == spjq_pkg::ACT_POP) && !w_empty;
    assign w_ctrl.id   = s_axis_tdata[15:0];
    assign w_ctrl.prio = s_axis_tdata[23:16];

    // head sees a valid, never-greater neighbor; tail sees an empty one
    assign w_edge_left  = '{valid: 1'b1, gt: 1'b0, id: '0, prio: '0};
    assign w_edge_right = '{valid: 1'b0, gt: 1'b0, id: '0, prio: '0};

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        spjq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  ((k == 0) ? w_edge_left : w_cell[(k == 0) ? 0 : k-1]),
            .i_right ((k == DEPTH-1) ? w_edge_right
                                     : w_cell[(k == DEPTH-1) ? k : k+1]),
            .o_state (w_cell[k])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = spjq_pkg::ST_DONE;
        n_rid    = '0;
        n_rprio  = '0;
        if (w_action == spjq_pkg::ACT_PUSH) begin
            if (w_full) begin
                n_status = spjq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = spjq_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
                n_rid   = w_cell[0].id;
                n_rprio = w_cell[0].prio;
            end
        end
    end

    assign w_count_ext = (CNT_W + 5)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_count   <= '0;
        end else begin
            if (w_accept) begin
                r_m_valid <= 1'b1;
                r_count   <= n_count;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_rprio  <= n_rprio;
            r_occ    <= w_count_ext[4:0];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_occ, r_rprio, r_rid, r_status};

    // checks on the cell chain
    logic [DEPTH-1:0] w_valid_vec;
    logic [DEPTH-1:0] w_misorder;

    for (genvar k = 0; k < DEPTH; k++) begin : g_chk
        assign w_valid_vec[k] = w_cell[k].valid;
        if (k == 0) begin : g_head
            assign w_misorder[k] = 1'b0;
        end else begin : g_body
            assign w_misorder[k] = w_cell[k].valid &&
                                   (!w_cell[k-1].valid || (w_cell[k-1].prio > w_cell[k].prio));
        end
    end

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(w_valid_vec))
        else $error("occupancy count disagrees with live cells");

    a_sorted_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_misorder == '0)
        else $error("cell chain not compact or not in priority order");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not add one job");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> (r_rid == $past(w_cell[0].id)) && (r_status == spjq_pkg::ST_DONE))
        else $error("pop did not return the head job");

endmodule

`default_nettype wire
